[rtl/core/dgc_pkg.sv]
// Shared types, register codes, widths and the decay table of the Gaussian cost cell.
package dgc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_Y     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 8'd7;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic [15:0] PEAK_RST     = 16'd65024;
    localparam logic [15:0] CUTOFF_RST   = 16'd2560;
    localparam logic [23:0] VARIANCE_RST = 24'd65536;
    localparam logic [23:0] GAIN_RST     = 24'd65536;

    localparam int VSQ_W     = 48;  // |v|^2
    localparam int DEN_W     = 57;  // forward variance, Q32
    localparam int SIDE_W    = 40;  // side variance, Q32
    localparam int MX2_W     = 80;  // projected distance squared, saturating
    localparam int E_W       = 21;  // exponent bits below the cap of 32.0
    localparam int FACT_W    = 31;  // decay factor, Q30
    localparam int EXP_STEPS = 21;

    localparam logic [FACT_W-1:0] ONE30 = 31'h4000_0000;

    // exp(-2^(b-16)) in Q30
    localparam logic [29:0] EXP_TAB [EXP_STEPS] = '{
        30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
        30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
        30'd1057095000, 30'd1040706261, 30'd1008687096, 30'd947573834,  30'd836230973,
        30'd651257337,  30'd395007542,  30'd145315154,  30'd19666268,   30'd360200,
        30'd121
    };

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SQUARE,
        CS_ROOT,
        CS_GAIN,
        CS_SCALE
    } t_cfg_state;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [15:0]        peak;
        logic [15:0]        cutoff;
        logic               vel_nz;
        logic [VSQ_W-1:0]   vel_sq;
        logic [DEN_W-1:0]   den_fwd;
        logic [SIDE_W-1:0]  den_side;
    } t_cfg;

endpackage

[rtl/core/directional_gaussian_cost_cell.sv]
// Top level of the directional Gaussian cost cell: front pipeline, dividers, decay, output.
//
// Usage:
//   Input: drive i_cell_x, i_cell_y, i_old_cost with start high; the transaction is
//   taken at an edge where start is high and busy is low. A new cell may follow every
//   cycle while busy stays low, so a costmap window streams at one cell per clock.
//   Output: o_strobe marks one cycle carrying o_new_cost and o_raised. The receiver
//   cannot stall, so the pipeline never holds; results leave in input order.
//   Pipeline: five front stages (offsets, projections, squares), 81 stages of the
//   projection divider, 22 stages of the variance divider, the exponent sum, 21 decay
//   multiply steps, the amplitude multiply and the output register. Throughput is one
//   cell per cycle while busy is low.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; ready is
//   always high and unknown indexes are dropped. Write only while no cell is in flight.
//   After each write (and after reset) busy stays high while a sequencer
//   squares the velocity, takes its square root one bit pair per cycle, and forms the
//   forward and side variances.
//   Reset: synchronous active low; registers return to their reset values and busy
//   rises until the derived values are ready.
module directional_gaussian_cost_cell #(
    parameter int COORD_FRAC_BITS = dgc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             i_cell_x,
    input  logic signed [31:0]             i_cell_y,
    input  logic [7:0]                     i_old_cost,
    output logic                           o_strobe,
    output logic [7:0]                     o_new_cost,
    output logic                           o_raised,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // exponent term = m2 * 2^(47-2F) / variance
    localparam int ESHIFT = 47 - 2 * COORD_FRAC_BITS;
    localparam int SHL    = (ESHIFT > 0) ? ESHIFT : 0;
    localparam int SHR    = (ESHIFT < 0) ? -ESHIFT : 0;
    localparam int N2_W   = dgc_pkg::MX2_W + SHL;
    localparam int SQ_W   = 113;
    localparam int DD_W   = 66;

    dgc_pkg::t_cfg cfg;
    logic          accept;

    dgc_cfg_unit u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_busy      (busy)
    );

    assign accept = start && !busy;

    // ---------------- stage 1: offsets from the seeker
    logic               r_s1_vld;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic [7:0]         r_s1_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= 33'(i_cell_x) - 33'(cfg.center_x);
        r_dy     <= 33'(i_cell_y) - 33'(cfg.center_y);
        r_s1_old <= i_old_cost;
    end

    // ---------------- stage 2: products with the velocity and own squares
    logic               r_s2_vld;
    logic signed [56:0] r_pxx, r_pyy, r_pxy, r_pyx;
    logic signed [65:0] r_sqx, r_sqy;
    logic [7:0]         r_s2_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pxx    <= r_dx * cfg.vel_x;
        r_pyy    <= r_dy * cfg.vel_y;
        r_pxy    <= r_dx * cfg.vel_y;
        r_pyx    <= r_dy * cfg.vel_x;
        r_sqx    <= r_dx * r_dx;
        r_sqy    <= r_dy * r_dy;
        r_s2_old <= r_s1_old;
    end

    // ---------------- stage 3: dot and cross products, side test
    logic signed [57:0] n_u;
    logic signed [57:0] n_w;
    logic               r_s3_vld;
    logic signed [57:0] r_u, r_w;
    logic [DD_W-1:0]    r_s3_dd;
    logic               r_s3_ahead;
    logic [7:0]         r_s3_old;

    assign n_u = 58'(r_pxx) + 58'(r_pyy);
    assign n_w = 58'(r_pxy) - 58'(r_pyx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_w        <= n_w;
        r_s3_dd    <= $unsigned(r_sqx) + $unsigned(r_sqy);
        r_s3_ahead <= cfg.vel_nz && !n_u[57] && (n_u != '0);
        r_s3_old   <= r_s2_old;
    end

    // ---------------- stage 4: partial products of |u|^2 and |w|^2
    logic [56:0] u_mag, w_mag;
    logic        r_s4_vld;
    logic [55:0] r_uhh, r_whh;
    logic [56:0] r_uhl, r_whl;
    logic [57:0] r_ull, r_wll;
    logic [DD_W-1:0] r_s4_dd;
    logic        r_s4_ahead;
    logic [7:0]  r_s4_old;

    assign u_mag = r_u[57] ? 57'(-r_u) : 57'(r_u);
    assign w_mag = r_w[57] ? 57'(-r_w) : 57'(r_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uhh      <= u_mag[56:29] * u_mag[56:29];
        r_uhl      <= u_mag[56:29] * u_mag[28:0];
        r_ull      <= u_mag[28:0] * u_mag[28:0];
        r_whh      <= w_mag[56:29] * w_mag[56:29];
        r_whl      <= w_mag[56:29] * w_mag[28:0];
        r_wll      <= w_mag[28:0] * w_mag[28:0];
        r_s4_dd    <= r_s3_dd;
        r_s4_ahead <= r_s3_ahead;
        r_s4_old   <= r_s3_old;
    end

    // ---------------- stage 5: sum the partials
    logic [SQ_W:0]   usq_full, wsq_full;
    logic            r_s5_vld;
    logic [SQ_W-1:0] r_usq, r_wsq;
    logic [DD_W-1:0] r_s5_dd;
    logic            r_s5_ahead;
    logic [7:0]      r_s5_old;

    assign usq_full = ((SQ_W+1)'(r_uhh) << 58) + ((SQ_W+1)'(r_uhl) << 30) + (SQ_W+1)'(r_ull);
    assign wsq_full = ((SQ_W+1)'(r_whh) << 58) + ((SQ_W+1)'(r_whl) << 30) + (SQ_W+1)'(r_wll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_usq      <= usq_full[SQ_W-1:0];
        r_wsq      <= wsq_full[SQ_W-1:0];
        r_s5_dd    <= r_s4_dd;
        r_s5_ahead <= r_s4_ahead;
        r_s5_old   <= r_s4_old;
    end

    // ---------------- projections squared over |v|^2
    logic                      d1x_vld, d1y_vld;
    logic [dgc_pkg::MX2_W-1:0] d1x_q, d1y_q;
    logic                      d1x_sat, d1y_sat;
    logic [DD_W:0]             d1x_pl;
    logic [7:0]                d1y_pl;

    dgc_div_pipe #(
        .N_W (SQ_W), .D_W (dgc_pkg::VSQ_W), .Q_W (dgc_pkg::MX2_W), .P_W (DD_W + 1)
    ) u_div_along (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_s5_vld), .i_num (r_usq), .i_den (cfg.vel_sq),
        .i_pl  ({r_s5_ahead, r_s5_dd}),
        .o_vld (d1x_vld), .o_quo (d1x_q), .o_sat (d1x_sat), .o_pl (d1x_pl)
    );

    dgc_div_pipe #(
        .N_W (SQ_W), .D_W (dgc_pkg::VSQ_W), .Q_W (dgc_pkg::MX2_W), .P_W (8)
    ) u_div_across (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_s5_vld), .i_num (r_wsq), .i_den (cfg.vel_sq), .i_pl (r_s5_old),
        .o_vld (d1y_vld), .o_quo (d1y_q), .o_sat (d1y_sat), .o_pl (d1y_pl)
    );

    // ---------------- exponent terms: pick branch, scale, divide by variance
    logic                      d1_ahead;
    logic [dgc_pkg::MX2_W-1:0] m2x, m2y;
    logic [N2_W-1:0]           n2x, n2y;
    logic [dgc_pkg::DEN_W-1:0] den_x, den_y;

    // a saturated projection is already all ones, which caps the term downstream
    assign d1_ahead = d1x_pl[DD_W] && (d1x_sat || !d1x_sat) && (d1y_sat || !d1y_sat);
    assign m2x   = d1_ahead ? d1x_q : dgc_pkg::MX2_W'(d1x_pl[DD_W-1:0]);
    assign m2y   = d1_ahead ? d1y_q : '0;
    assign den_x = d1_ahead ? cfg.den_fwd : dgc_pkg::DEN_W'(cfg.den_side);
    assign den_y = dgc_pkg::DEN_W'(cfg.den_side);
    assign n2x   = (N2_W'(m2x) << SHL) >> SHR;
    assign n2y   = (N2_W'(m2y) << SHL) >> SHR;

    logic                    ex_vld, ey_vld;
    logic [dgc_pkg::E_W-1:0] ex_q, ey_q;
    logic                    ex_sat, ey_sat;
    logic [3:0]              ex_pl, ey_pl;

    // old cost rides split across the two lanes
    dgc_div_pipe #(
        .N_W (N2_W), .D_W (dgc_pkg::DEN_W), .Q_W (dgc_pkg::E_W), .P_W (4)
    ) u_term_along (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (d1x_vld), .i_num (n2x), .i_den (den_x), .i_pl (d1y_pl[7:4]),
        .o_vld (ex_vld), .o_quo (ex_q), .o_sat (ex_sat), .o_pl (ex_pl)
    );

    dgc_div_pipe #(
        .N_W (N2_W), .D_W (dgc_pkg::DEN_W), .Q_W (dgc_pkg::E_W), .P_W (4)
    ) u_term_across (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (d1y_vld), .i_num (n2y), .i_den (den_y), .i_pl (d1y_pl[3:0]),
        .o_vld (ey_vld), .o_quo (ey_q), .o_sat (ey_sat), .o_pl (ey_pl)
    );

    // ---------------- exponent sum; each term caps at 32.0
    logic [dgc_pkg::E_W:0]   term_x, term_y;
    logic                    r_e_vld;
    logic [dgc_pkg::E_W+1:0] r_e;
    logic [7:0]              r_e_old;

    assign term_x = ex_sat ? (dgc_pkg::E_W+1)'(1) << dgc_pkg::E_W : {1'b0, ex_q};
    assign term_y = ey_sat ? (dgc_pkg::E_W+1)'(1) << dgc_pkg::E_W : {1'b0, ey_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= ex_vld && ey_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= (dgc_pkg::E_W+2)'(term_x) + (dgc_pkg::E_W+2)'(term_y);
        r_e_old <= {ex_pl, ey_pl};
    end

    // ---------------- decay factor
    logic                         dc_vld;
    logic [dgc_pkg::FACT_W-1:0]   dc_factor;
    logic [7:0]                   dc_old;

    dgc_decay_pipe #(.P_W (8)) u_decay (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_e_vld),
        .i_e      (r_e[dgc_pkg::E_W-1:0]),
        .i_zero   (r_e[dgc_pkg::E_W+1:dgc_pkg::E_W] != '0),
        .i_pl     (r_e_old),
        .o_vld    (dc_vld),
        .o_factor (dc_factor),
        .o_pl     (dc_old)
    );

    // ---------------- amplitude
    logic [46:0] amp_prod;
    logic        r_a_vld;
    logic [15:0] r_a16;
    logic [7:0]  r_a_old;

    assign amp_prod = 47'(cfg.peak) * 47'(dc_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= dc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a16   <= amp_prod[45:30];
        r_a_old <= dc_old;
    end

    // ---------------- output: apply cutoff, keep the larger cost
    logic apply;

    assign apply = (r_a_old != 8'hFF) && (cfg.cutoff < cfg.peak) && (r_a16 >= cfg.cutoff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            o_raised <= 1'b0;
        end else begin
            o_strobe <= r_a_vld;
            o_raised <= r_a_vld && apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply && (r_a16[15:8] > r_a_old)) begin
            o_new_cost <= r_a16[15:8];
        end else begin
            o_new_cost <= r_a_old;
        end
    end

    // ---------------- checks
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> busy)
        else $error("config write did not restart the derivation");

    a_no_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !r_s1_vld)
        else $error("cell entered while busy");

    a_raised_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_raised)
        else $error("raised without a result");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_vld == ey_vld)
        else $error("exponent lanes out of step");

endmodule

[rtl/core/dgc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module dgc_div_pipe #(
    parameter int N_W = 113,
    parameter int D_W = 48,
    parameter int Q_W = 80,
    parameter int P_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [P_W-1:0] i_pl,
    output logic           o_vld,
    output logic [Q_W-1:0] o_quo,
    output logic           o_sat,
    output logic [P_W-1:0] o_pl
);

    localparam int HI_W  = N_W - Q_W;
    localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;
    logic             sat_in;

    logic           r_vld [Q_W+1];
    logic           r_sat [Q_W+1];
    logic [D_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0] r_nq  [Q_W+1];
    logic [D_W-1:0] r_den [Q_W+1];
    logic [P_W-1:0] r_pl  [Q_W+1];

    // quotient overflows when the top part alone reaches the divisor
    assign hi_ext  = CMP_W'(i_num[N_W-1:Q_W]);
    assign den_ext = CMP_W'(i_den);
    assign sat_in  = (hi_ext >= den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat[0] <= sat_in;
        r_rem[0] <= sat_in ? '0 : hi_ext[D_W-1:0];
        r_nq[0]  <= i_num[Q_W-1:0];
        r_den[0] <= i_den;
        r_pl[0]  <= i_pl;
    end

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [D_W:0] trial;
        logic [D_W:0] diff;
        logic         ge;

        assign trial = {r_rem[i], r_nq[i][Q_W-1]};
        assign diff  = trial - {1'b0, r_den[i]};
        assign ge    = (trial >= {1'b0, r_den[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sat[i+1] <= r_sat[i];
            r_rem[i+1] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_nq[i+1]  <= {r_nq[i][Q_W-2:0], ge};
            r_den[i+1] <= r_den[i];
            r_pl[i+1]  <= r_pl[i];
        end
    end

    assign o_vld = r_vld[Q_W];
    assign o_sat = r_sat[Q_W];
    assign o_quo = r_sat[Q_W] ? '1 : r_nq[Q_W];
    assign o_pl  = r_pl[Q_W];

endmodule

[rtl/core/dgc_decay_pipe.sv]
// Decay factor pipeline: one table multiply per exponent bit.
module dgc_decay_pipe #(
    parameter int P_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [dgc_pkg::E_W-1:0]   i_e,
    input  logic                      i_zero,
    input  logic [P_W-1:0]            i_pl,
    output logic                      o_vld,
    output logic [dgc_pkg::FACT_W-1:0] o_factor,
    output logic [P_W-1:0]            o_pl
);

    localparam int N = dgc_pkg::EXP_STEPS;

    logic                       r_vld [N];
    logic [dgc_pkg::FACT_W-1:0] r_acc [N];
    logic [dgc_pkg::E_W-1:0]    r_e   [N];
    logic [P_W-1:0]             r_pl  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                       vld_in;
        logic [dgc_pkg::FACT_W-1:0] acc_in;
        logic [dgc_pkg::E_W-1:0]    e_in;
        logic [P_W-1:0]             pl_in;
        logic [60:0]                prod;

        if (k == 0) begin : g_first
            assign vld_in = i_vld;
            assign acc_in = i_zero ? '0 : dgc_pkg::ONE30;
            assign e_in   = i_e;
            assign pl_in  = i_pl;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign acc_in = r_acc[k-1];
            assign e_in   = r_e[k-1];
            assign pl_in  = r_pl[k-1];
        end

        assign prod = 61'(acc_in) * 61'(dgc_pkg::EXP_TAB[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[k] <= e_in[k] ? prod[60:30] : acc_in;
            r_e[k]   <= e_in;
            r_pl[k]  <= pl_in;
        end
    end

    assign o_vld    = r_vld[N-1];
    assign o_factor = r_acc[N-1];
    assign o_pl     = r_pl[N-1];

endmodule

[rtl/core/dgc_cfg_unit.sv]
// Configuration registers and the sequencer that derives speed and variances from them.
module dgc_cfg_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dgc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dgc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dgc_pkg::t_cfg                    o_cfg,
    output logic                             o_busy
);

    dgc_pkg::t_cfg_state r_state;
    dgc_pkg::t_cfg_state n_state;

    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic signed [23:0] r_vel_x;
    logic signed [23:0] r_vel_y;
    logic [15:0]        r_peak;
    logic [15:0]        r_cutoff;
    logic [23:0]        r_variance;
    logic [23:0]        r_gain;

    logic [23:0]                 r_var1;
    logic [dgc_pkg::VSQ_W-1:0]   r_vsq;
    logic [dgc_pkg::VSQ_W-1:0]   r_rem;
    logic [dgc_pkg::VSQ_W-1:0]   r_root;
    logic [dgc_pkg::VSQ_W-1:0]   r_bit;
    logic [32:0]                 r_k16;
    logic [dgc_pkg::DEN_W-1:0]   r_den_fwd;

    logic                        cfg_we;
    logic signed [47:0]          sq_x;
    logic signed [47:0]          sq_y;
    logic [dgc_pkg::VSQ_W-1:0]   n_vsq;
    logic [dgc_pkg::VSQ_W-1:0]   root_trial;
    logic [47:0]                 gain_prod;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    assign sq_x       = r_vel_x * r_vel_x;
    assign sq_y       = r_vel_y * r_vel_y;
    assign n_vsq      = $unsigned(sq_x) + $unsigned(sq_y);
    assign root_trial = r_root + r_bit;
    assign gain_prod  = r_gain * r_root[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_vel_x    <= '0;
            r_vel_y    <= '0;
            r_peak     <= dgc_pkg::PEAK_RST;
            r_cutoff   <= dgc_pkg::CUTOFF_RST;
            r_variance <= dgc_pkg::VARIANCE_RST;
            r_gain     <= dgc_pkg::GAIN_RST;
        end else if (cfg_we) begin
            case (i_cfg_index)
                dgc_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                dgc_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                dgc_pkg::CFG_VEL_X:    r_vel_x    <= i_cfg_data[23:0];
                dgc_pkg::CFG_VEL_Y:    r_vel_y    <= i_cfg_data[23:0];
                dgc_pkg::CFG_PEAK:     r_peak     <= i_cfg_data[15:0];
                dgc_pkg::CFG_CUTOFF:   r_cutoff   <= i_cfg_data[15:0];
                dgc_pkg::CFG_VARIANCE: r_variance <= i_cfg_data[23:0];
                dgc_pkg::CFG_GAIN:     r_gain     <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgc_pkg::CS_SQUARE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgc_pkg::CS_IDLE:   n_state = dgc_pkg::CS_IDLE;
            dgc_pkg::CS_SQUARE: n_state = dgc_pkg::CS_ROOT;
            dgc_pkg::CS_ROOT: begin
                if ((r_bit >> 2) == '0) begin
                    n_state = dgc_pkg::CS_GAIN;
                end
            end
            dgc_pkg::CS_GAIN:   n_state = dgc_pkg::CS_SCALE;
            dgc_pkg::CS_SCALE:  n_state = dgc_pkg::CS_IDLE;
            default:            n_state = dgc_pkg::CS_SQUARE;
        endcase
        // any write restarts the derivation
        if (cfg_we) begin
            n_state = dgc_pkg::CS_SQUARE;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dgc_pkg::CS_SQUARE: begin
                r_var1 <= (r_variance == '0) ? 24'd1 : r_variance;
                r_vsq  <= n_vsq;
                r_rem  <= n_vsq;
                r_root <= '0;
                r_bit  <= dgc_pkg::VSQ_W'(1) << (dgc_pkg::VSQ_W - 2);
            end
            dgc_pkg::CS_ROOT: begin
                if (r_rem >= root_trial) begin
                    r_rem  <= r_rem - root_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            dgc_pkg::CS_GAIN: begin
                r_k16 <= 33'(gain_prod[47:16]) + 33'h1_0000;
            end
            dgc_pkg::CS_SCALE: begin
                r_den_fwd <= dgc_pkg::DEN_W'(r_var1) * dgc_pkg::DEN_W'(r_k16);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != dgc_pkg::CS_IDLE);

    assign o_cfg.center_x = r_center_x;
    assign o_cfg.center_y = r_center_y;
    assign o_cfg.vel_x    = r_vel_x;
    assign o_cfg.vel_y    = r_vel_y;
    assign o_cfg.peak     = r_peak;
    assign o_cfg.cutoff   = r_cutoff;
    assign o_cfg.vel_nz   = (r_vel_x != '0) || (r_vel_y != '0);
    assign o_cfg.vel_sq   = r_vsq;
    assign o_cfg.den_fwd  = r_den_fwd;
    assign o_cfg.den_side = {r_var1, 16'h0000};

endmodule

[bench/tb_directional_gaussian_cost_cell.sv]
// Self-checking testbench for the directional Gaussian cost cell.
module tb_directional_gaussian_cost_cell;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LATENCY    = 131;
    localparam int          SETTLE     = LATENCY + 40;
    localparam longint      CYCLE_CAP  = 400000;
    localparam int          SHIFT_E    = 47 - 2 * dgc_pkg::COORD_FRAC_BITS_DEF;
    localparam logic [63:0] E_CAP      = 64'd32 << 16;
    // index past the register file, must be dropped by the block
    localparam logic [dgc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;
    localparam int          N_CELLS    = 13;

    typedef struct packed {
        logic [7:0] cost;
        logic       raised;
    } t_cost;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [7:0]  old;
        logic        known;   // expected value typed in below
        logic [7:0]  cost;
        logic        raised;
    } t_cell_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic signed [31:0]             i_cell_x;
    logic signed [31:0]             i_cell_y;
    logic [7:0]                     i_old_cost;
    logic                           o_strobe;
    logic [7:0]                     o_new_cost;
    logic                           o_raised;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [dgc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dgc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    directional_gaussian_cost_cell dut (.*);

    // Shadow copy of the register file used by the cost predictor.
    logic [31:0] sh_cx, sh_cy;
    logic [23:0] sh_vx, sh_vy, sh_var, sh_gain;
    logic [15:0] sh_peak, sh_cut;

    t_cost  pending_costs[$];
    int     errors;
    longint cycles;
    int     idle_pct;

    // Directed cells under the reset configuration: center at the origin,
    // zero velocity, peak 254.0, cutoff 10.0, unit variance.
    t_cell_row cells [N_CELLS] = '{
        '{32'd0, 32'd0, 8'd0, 1'b1, 8'd254, 1'b1},          // peak of the Gaussian
        '{32'd0, 32'd0, 8'd255, 1'b1, 8'd255, 1'b0},        // unknown cell passes
        '{32'd0, 32'd0, 8'd254, 1'b1, 8'd254, 1'b1},        // tie with old cost
        '{32'h7FFF_FFFF, 32'h8000_0000, 8'd7, 1'b1, 8'd7, 1'b0},  // far away, capped
        '{32'h8000_0000, 32'h8000_0000, 8'd0, 1'b1, 8'd0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b1, 8'd255, 1'b0},
        '{32'h0001_0000, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},     // one metre out
        '{32'd0, 32'hFFFF_0000, 8'd100, 1'b0, 8'd0, 1'b0},
        '{32'h0002_0000, 32'h0001_8000, 8'd3, 1'b0, 8'd0, 1'b0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 8'd200, 1'b0, 8'd0, 1'b0},
        '{32'h0003_0000, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},    // near the cutoff
        '{32'h0002_8000, 32'h0000_4000, 8'd1, 1'b0, 8'd0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd128, 1'b1, 8'd128, 1'b0}
    };

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= r + bit_v) begin
                n = n - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // One exponent term: distance squared over variance, Q16, capped at 32.0.
    function automatic logic [63:0] exp_term(logic [127:0] m2, logic [63:0] v32);
        logic [127:0] scaled, q;
        scaled = (SHIFT_E >= 0) ? (m2 << SHIFT_E) : (m2 >> -SHIFT_E);
        q = scaled / {64'd0, v32};
        return (q >= {64'd0, E_CAP}) ? E_CAP : q[63:0];
    endfunction

    function automatic logic [63:0] decay_factor(logic [63:0] e16);
        logic [63:0] acc;
        acc = 64'd1 << 30;
        if (e16 >= E_CAP) return 64'd0;
        for (int b = 0; b < dgc_pkg::EXP_STEPS; b++)
            if (e16[b]) acc = (acc * {34'd0, dgc_pkg::EXP_TAB[b]}) >> 30;
        return acc;
    endfunction

    function automatic t_cost predict_cost(logic [31:0] cx, logic [31:0] cy, logic [7:0] old);
        longint      dx, dy, vx, vy, u, w;
        logic [63:0] v2, spd, k16, var_eff, side_var, e16, a16, mu, mw;
        logic [127:0] mx2, my2, wu, ww, wx, wy;
        t_cost       r;
        dx = longint'($signed(cx)) - longint'($signed(sh_cx));
        dy = longint'($signed(cy)) - longint'($signed(sh_cy));
        vx = longint'($signed(sh_vx));
        vy = longint'($signed(sh_vy));
        var_eff = (sh_var == 0) ? 64'd1 : {40'd0, sh_var};
        side_var = var_eff << 16;
        r.cost = old;
        r.raised = 1'b0;
        if (old == 8'd255 || sh_cut >= sh_peak) return r;
        u = dx * vx + dy * vy;
        if ((vx != 0 || vy != 0) && u > 0) begin
            w = dx * vy - dy * vx;
            v2 = vx * vx + vy * vy;
            spd = int_sqrt(v2);
            k16 = 64'd65536 + (({40'd0, sh_gain} * spd) >> 16);
            mu = (u < 0) ? -u : u;
            mw = (w < 0) ? -w : w;
            wu = {64'd0, mu};
            ww = {64'd0, mw};
            mx2 = (wu * wu) / {64'd0, v2};
            my2 = (ww * ww) / {64'd0, v2};
            e16 = exp_term(mx2, var_eff * k16) + exp_term(my2, side_var);
        end else begin
            wx = {64'd0, 64'((dx < 0) ? -dx : dx)};
            wy = {64'd0, 64'((dy < 0) ? -dy : dy)};
            e16 = exp_term(wx * wx + wy * wy, side_var);
        end
        a16 = ({48'd0, sh_peak} * decay_factor(e16)) >> 30;
        if (a16 < {48'd0, sh_cut}) return r;
        r.cost = (a16[15:8] > old) ? a16[15:8] : old;
        r.raised = 1'b1;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check each result strobe against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_cost want;
        if (i_rst_n && o_strobe) begin
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected result cost=%0d raised=%0b",
                         $time, o_new_cost, o_raised);
                errors = errors + 1;
            end else begin
                want = pending_costs.pop_front();
                if (o_new_cost !== want.cost) begin
                    $display("%0t: new_cost expected %0d actual %0d",
                             $time, want.cost, o_new_cost);
                    errors = errors + 1;
                end
                if (o_raised !== want.raised) begin
                    $display("%0t: raised expected %0b actual %0b",
                             $time, want.raised, o_raised);
                    errors = errors + 1;
                end
            end
        end
    end

    // Hold start until the transaction is taken, then, with a chance of idle_pct percent, drop it for a random gap.
    task automatic send_cell(logic [31:0] cx, logic [31:0] cy, logic [7:0] old,
                             logic known, t_cost typed);
        int gap;
        start      <= 1'b1;
        i_cell_x   <= cx;
        i_cell_y   <= cy;
        i_old_cost <= old;
        do @(posedge i_clk); while (busy);
        pending_costs.push_back(known ? typed : predict_cost(cx, cy, old));
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the pipeline so the block is idle.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dgc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dgc_pkg::CFG_CENTER_X: sh_cx   = data;
            dgc_pkg::CFG_CENTER_Y: sh_cy   = data;
            dgc_pkg::CFG_VEL_X:    sh_vx   = data[23:0];
            dgc_pkg::CFG_VEL_Y:    sh_vy   = data[23:0];
            dgc_pkg::CFG_PEAK:     sh_peak = data[15:0];
            dgc_pkg::CFG_CUTOFF:   sh_cut  = data[15:0];
            dgc_pkg::CFG_VARIANCE: sh_var  = data[23:0];
            dgc_pkg::CFG_GAIN:     sh_gain = data[23:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_setup(logic [31:0] cx, logic [31:0] cy, logic [23:0] vx,
                              logic [23:0] vy, logic [15:0] pk, logic [15:0] cut,
                              logic [23:0] vr, logic [23:0] gn);
        drain();
        write_reg(dgc_pkg::CFG_CENTER_X, cx);
        write_reg(dgc_pkg::CFG_CENTER_Y, cy);
        write_reg(dgc_pkg::CFG_VEL_X, {8'd0, vx});
        write_reg(dgc_pkg::CFG_VEL_Y, {8'd0, vy});
        write_reg(dgc_pkg::CFG_PEAK, {16'd0, pk});
        write_reg(dgc_pkg::CFG_CUTOFF, {16'd0, cut});
        write_reg(dgc_pkg::CFG_VARIANCE, {8'd0, vr});
        write_reg(dgc_pkg::CFG_GAIN, {8'd0, gn});
    endtask

    // Mostly cells within a few metres of the seeker, where the Gaussian
    // lands; the rest spread over the whole coordinate range.
    task automatic random_cells(int count);
        logic [31:0] cx, cy;
        logic [7:0]  old;
        int          reach;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                cx = $urandom;
                cy = $urandom;
            end else begin
                reach = dgc_pkg::COORD_FRAC_BITS_DEF + int'($urandom_range(0, 3));
                cx = sh_cx + ($urandom & ((32'd1 << reach) - 1)) - (32'd1 << (reach - 1));
                cy = sh_cy + ($urandom & ((32'd1 << reach) - 1)) - (32'd1 << (reach - 1));
            end
            case ($urandom_range(7))
                0:       old = 8'd255;
                1:       old = 8'd0;
                default: old = 8'($urandom_range(0, 255));
            endcase
            send_cell(cx, cy, old, 1'b0, '0);
            // midway through a run at 65 percent idle, hold off until the pipeline is empty
            if (n == count / 2 && idle_pct == 65) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_costs.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [23:0] rand_vel();
        case ($urandom_range(3))
            0:       return 24'd0;
            1:       return 24'($signed($urandom_range(0, 262144)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int pcts [4];
        pcts        = '{0, 65, 16, 0};
        errors      = 0;
        cycles      = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cell_x    = '0;
        i_cell_y    = '0;
        i_old_cost  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sh_cx = 0; sh_cy = 0; sh_vx = 0; sh_vy = 0;
        sh_peak = dgc_pkg::PEAK_RST;
        sh_cut  = dgc_pkg::CUTOFF_RST;
        sh_var  = dgc_pkg::VARIANCE_RST;
        sh_gain = dgc_pkg::GAIN_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cells under the reset values.
        foreach (cells[i])
            send_cell(cells[i].cx, cells[i].cy, cells[i].old, cells[i].known,
                      '{cells[i].cost, cells[i].raised});
        idle_pct = 65;
        random_cells(60);

        // Unused index must leave the registers alone.
        drain();
        write_reg(CFG_UNUSED, 32'h0000_0001);
        idle_pct = 0;
        random_cells(20);

        // Unit speed along +x: cells ahead stretched, behind isotropic.
        load_setup(32'd0, 32'd0, 24'h01_0000, 24'd0, 16'd65024, 16'd2560,
                   24'h01_0000, 24'h01_0000);
        idle_pct = 16;
        random_cells(60);

        // Velocity and gain extremes with the widest variance.
        load_setup(32'd0, 32'd0, 24'h80_0000, 24'h7F_FFFF, 16'd65535, 16'd0,
                   24'hFF_FFFF, 24'hFF_FFFF);
        idle_pct = 0;
        random_cells(50);

        // Zero variance is taken as the smallest one; no gain.
        load_setup(32'h0001_0000, 32'hFFFF_0000, 24'h00_0001, 24'hFF_FFFF, 16'd65535,
                   16'd1, 24'd0, 24'd0);
        random_cells(40);

        // Cutoff not below the peak disables the Gaussian.
        load_setup(32'h1234_5678, 32'h8765_4321, 24'h00_8000, 24'h00_8000, 16'd100,
                   16'd100, 24'h01_0000, 24'h01_0000);
        idle_pct = 65;
        random_cells(30);
        load_setup(32'd0, 32'd0, 24'd0, 24'd0, 16'd0, 16'd0, 24'd1, 24'd0);
        random_cells(20);

        // Seeker at the coordinate extremes.
        load_setup(32'h8000_0000, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 16'd65535,
                   16'd0, 24'h04_0000, 24'h00_4000);
        idle_pct = 16;
        random_cells(40);

        // Random setups.
        for (int ph = 0; ph < 12; ph++) begin
            load_setup($urandom, $urandom, rand_vel(), rand_vel(), 16'($urandom),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
                       ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(1, 262144)),
                       24'($urandom));
            // center near the origin for half of them so cells can cover it
            if (ph[0]) begin
                write_reg(dgc_pkg::CFG_CENTER_X, $urandom_range(0, 524288) - 262144);
                write_reg(dgc_pkg::CFG_CENTER_Y, $urandom_range(0, 524288) - 262144);
            end
            idle_pct = pcts[ph % 4];
            random_cells(35);
        end

        start <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[directional_gaussian_cost_cell.f]
rtl/core/dgc_pkg.sv
rtl/core/dgc_div_pipe.sv
rtl/core/dgc_decay_pipe.sv
rtl/core/dgc_cfg_unit.sv
rtl/core/directional_gaussian_cost_cell.sv
bench/tb_directional_gaussian_cost_cell.sv
